// ===== src/ilst_pkg.sv =====
// Shared types, constants and word conversion helpers for the indexed ordered list.
// Used by ilst_ram users and by the indexed_ordered_list top level.
package ilst_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // Port field widths
    localparam int ACTION_W = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [COUNT_W-1:0]    count_t;

    localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Fit an input value into a stored word: cut or zero-extend.
    function automatic word_t to_word(input value_t v);
        word_t w;
        w = '0;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            if (i < VALUE_W)
                w[i] = v[i];
        end
        return w;
    endfunction

    // Bring a stored word back to the result field: cut or zero-extend.
    function automatic value_t from_word(input word_t w);
        value_t v;
        v = '0;
        for (int i = 0; i < VALUE_W; i++)
        begin
            if (i < DATA_WIDTH)
                v[i] = w[i];
        end
        return v;
    endfunction

endpackage

// ===== src/ilst_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ilst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/indexed_ordered_list.sv =====
// Indexed ordered list: insert, remove, read or clear by position over one RAM.
// Clear and faulted commands skip the RAM; read waits for its RAM read data; insert and
// remove shift the later entries first. One item at a time, busy high until done.
// The shift loop moves one entry per cycle through the single RAM read and write port.
// Reset (async, rst_n low) empties the list; stored words stay undefined until written.
// Results are strobed by done for one cycle; the receiver cannot stall.
module indexed_ordered_list (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ilst_pkg::ACTION_W-1:0]  action,
    input  logic [ilst_pkg::POS_W-1:0]     position,
    input  logic signed [ilst_pkg::VALUE_W-1:0] value,
    output logic                           done,
    output logic signed [ilst_pkg::VALUE_W-1:0] read_value,
    output logic [ilst_pkg::COUNT_W-1:0]   count,
    output logic [ilst_pkg::STATUS_W-1:0]  status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REM_HEAD,
        S_REM_SHIFT,
        S_RD_WAIT
    } state_t;

    state_t                state_reg, state_next;
    ilst_pkg::cnt_t        cnt_reg, cnt_next;
    ilst_pkg::cnt_t        idx_reg, idx_next;
    ilst_pkg::addr_t       pos_reg, pos_next;
    ilst_pkg::value_t      val_reg, val_next;
    logic                  pend_reg, pend_next;
    ilst_pkg::addr_t       pend_addr_reg, pend_addr_next;
    logic                  done_reg, done_next;
    ilst_pkg::value_t      rv_reg, rv_next;
    ilst_pkg::status_t     status_reg, status_next;

    logic                  wr_en;
    ilst_pkg::addr_t       wr_addr;
    ilst_pkg::word_t       wr_data;
    logic                  rd_en;
    ilst_pkg::addr_t       rd_addr;
    ilst_pkg::word_t       rd_data;

    logic                  accept;
    ilst_pkg::cmp_t        pos_cmp;
    ilst_pkg::cmp_t        cnt_cmp;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign pos_cmp = ilst_pkg::cmp_t'(position);
    assign cnt_cmp = ilst_pkg::cmp_t'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        done_next      = 1'b0;
        rv_next        = rv_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = ilst_pkg::addr_t'(position);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next  = ilst_pkg::addr_t'(position);
                    val_next  = value;
                    pend_next = 1'b0;
                    case (action)
                        ilst_pkg::ACT_INSERT:
                        begin
                            if (cnt_reg == ilst_pkg::DEPTH_CNT)
                            begin
                                done_next   = 1'b1;
                                rv_next     = '0;
                                status_next = ilst_pkg::ST_FULL;
                            end
                            else if (pos_cmp > cnt_cmp)
                            begin
                                done_next   = 1'b1;
                                rv_next     = '0;
                                status_next = ilst_pkg::ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                state_next = S_INS_SHIFT;
                            end
                        end
                        ilst_pkg::ACT_REMOVE, ilst_pkg::ACT_READ:
                        begin
                            if (pos_cmp >= cnt_cmp)
                            begin
                                done_next   = 1'b1;
                                rv_next     = '0;
                                status_next = ilst_pkg::ST_RANGE;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = ilst_pkg::cnt_t'(position) + 1'b1;
                                if (action == ilst_pkg::ACT_REMOVE)
                                    state_next = S_REM_HEAD;
                                else
                                    state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            // clear: drop the count, keep the stored words
                            cnt_next    = '0;
                            done_next   = 1'b1;
                            rv_next     = '0;
                            status_next = ilst_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_INS_SHIFT:
            begin
                // move entry idx-1 up to idx, one per cycle, top down
                if (pend_reg)
                    wr_en = 1'b1;
                if (idx_reg != ilst_pkg::cnt_t'(pos_reg))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ilst_pkg::addr_t'(idx_reg - 1'b1);
                    pend_next      = 1'b1;
                    pend_addr_next = ilst_pkg::addr_t'(idx_reg);
                    idx_next       = idx_reg - 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = pos_reg;
                wr_data     = ilst_pkg::to_word(val_reg);
                cnt_next    = cnt_reg + 1'b1;
                done_next   = 1'b1;
                rv_next     = '0;
                status_next = ilst_pkg::ST_OK;
                state_next  = S_IDLE;
            end

            S_REM_HEAD:
            begin
                rv_next    = ilst_pkg::from_word(rd_data);
                state_next = S_REM_SHIFT;
            end

            S_REM_SHIFT:
            begin
                // move entry idx down to idx-1, bottom up
                if (pend_reg)
                    wr_en = 1'b1;
                if (idx_reg != cnt_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ilst_pkg::addr_t'(idx_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = ilst_pkg::addr_t'(idx_reg - 1'b1);
                    idx_next       = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next   = 1'b0;
                    cnt_next    = cnt_reg - 1'b1;
                    done_next   = 1'b1;
                    status_next = ilst_pkg::ST_OK;
                    state_next  = S_IDLE;
                end
            end

            S_RD_WAIT:
            begin
                rv_next     = ilst_pkg::from_word(rd_data);
                done_next   = 1'b1;
                status_next = ilst_pkg::ST_OK;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            pend_addr_reg <= '0;
            rv_reg        <= '0;
            status_reg    <= ilst_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            pend_addr_reg <= pend_addr_next;
            rv_reg        <= rv_next;
            status_reg    <= status_next;
        end
    end

    ilst_ram #(
        .WIDTH (ilst_pkg::DATA_WIDTH),
        .DEPTH (ilst_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign done       = done_reg;
    assign read_value = rv_reg;
    assign count      = ilst_pkg::count_t'(cnt_reg);
    assign status     = status_reg;

    // A result only follows an accepted item or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a command");

    // The count never passes the list depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ilst_pkg::DEPTH_CNT)
        else $error("entry count beyond depth");

    // A full status is only reported on a full list
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ilst_pkg::ST_FULL) |-> (cnt_reg == ilst_pkg::DEPTH_CNT))
        else $error("full status on a list with room");

    // The RAM is never written while the block is idle
    a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("RAM write while idle");

    // A shift leaves with no pending write
    a_exit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(busy) && !busy) |-> !pend_reg)
        else $error("pending write lost at end of command");

endmodule
